// File: src/nms_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the edge non-maximum suppression block
package nms_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAG_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int FILL_W     = COL_W + 1;
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int ROW_W      = 13;
  localparam int PEND_W     = 11;
  localparam int CFG_W      = 13;

  typedef logic [MAG_W-1:0] mag_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    DIR_VERT    = 2'd0,
    DIR_DIAG_UP = 2'd1,
    DIR_HORZ    = 2'd2,
    DIR_DIAG_DN = 2'd3
  } dir_e;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    mag_t up;
    mag_t mid;
    mag_t dn;
  } column_t;

  typedef struct packed {
    mag_t upper;
    mag_t center;
    dir_e dir;
  } store_word_t;

  typedef struct packed {
    logic             keep;
    logic             emit;
    logic [COL_W-1:0] col;
    logic             vl;
    logic             vr;
    logic             vu;
    logic             vd;
    logic             fe;
  } ctl_t;

endpackage

// File: src/nms_ram.sv
`timescale 1ns / 1ps
// generic single-write, registered-read ram
module nms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/nms_col_cell.sv
`timescale 1ns / 1ps
// one window column cell: holds three magnitudes and passes them on
module nms_col_cell
  import nms_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  column_t col_in,
  output column_t col_out
);

  column_t col_r;
  column_t col_nxt;

  always_comb begin
    col_nxt = col_r;
    if (en) begin
      col_nxt = col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

// File: src/nms_ctrl.sv
`timescale 1ns / 1ps
// frame counters, pending count, config registers and border flags
module nms_ctrl
  import nms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             acc,
  input  logic             opcode,
  output ctl_t             ctl
);

  logic [WID_W-1:0]  w_r, w_nxt;
  logic [HGT_W-1:0]  h_r, h_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;

  logic              restart;
  logic [COL_W-1:0]  col_b, col_cur;
  logic [ROW_W-1:0]  row_b, row_p, t;
  logic [PEND_W-1:0] pend_b, pend_inc, pend_new, w_p1;
  logic [WID_W-1:0]  col_p1, raw_w;
  logic [HGT_W-1:0]  raw_h;
  logic              wrap, col_zero, row_zero, corner;

  always_comb begin
    restart  = (op_e'(opcode) == OP_PIXEL) && (ROW_W'(h_r) <= row_r);
    col_b    = restart ? '0 : col_r;
    row_b    = restart ? '0 : row_r;
    pend_b   = restart ? '0 : pend_r;
    col_cur  = ({1'b0, col_b} >= w_r) ? '0 : col_b;
    w_p1     = PEND_W'(w_r) + PEND_W'(1);
    pend_inc = pend_b + PEND_W'(1);

    ctl.col = col_cur;
    if (op_e'(opcode) == OP_PIXEL) begin
      ctl.keep = 1'b1;
      ctl.emit = pend_inc > w_p1;
      pend_new = ctl.emit ? w_p1 : pend_inc;
    end else begin
      ctl.keep = pend_r != '0;
      ctl.emit = 1'b1;
      pend_new = pend_r - PEND_W'(1);
    end

    col_p1 = {1'b0, col_cur} + WID_W'(1);
    wrap   = col_p1 >= w_r;
    row_p  = row_b + ROW_W'(wrap);

    col_zero = col_cur == '0;
    row_zero = row_b == '0;
    corner   = col_zero && row_zero;
    t        = col_zero ? (row_b - ROW_W'(1)) : row_b;
    ctl.vu   = corner ? 1'b1 : (t != ROW_W'(1));
    ctl.vd   = corner ? 1'b0 : (t < ROW_W'(h_r));
    ctl.fe   = col_zero && !row_zero && (t == ROW_W'(h_r));
    ctl.vl   = col_zero ? (w_r > WID_W'(1)) : (col_cur > COL_W'(1));
    ctl.vr   = !col_zero;

    raw_w = cfg_data[WID_W-1:0];
    raw_h = cfg_data[HGT_W-1:0];

    w_nxt    = w_r;
    h_nxt    = h_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    if (cfg_we) begin
      unique case (reg_idx_e'(cfg_idx))
        REG_IMAGE_WIDTH: begin
          if (raw_w == '0) begin
            w_nxt = WID_W'(1);
          end else if (raw_w > WID_W'(MAX_WIDTH)) begin
            w_nxt = WID_W'(MAX_WIDTH);
          end else begin
            w_nxt = raw_w;
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (raw_h == '0) begin
            h_nxt = HGT_W'(1);
          end else if (raw_h > HGT_W'(MAX_HEIGHT)) begin
            h_nxt = HGT_W'(MAX_HEIGHT);
          end else begin
            h_nxt = raw_h;
          end
        end
        default: begin
          w_nxt = w_r;
        end
      endcase
      col_nxt  = '0;
      row_nxt  = '0;
      pend_nxt = '0;
    end else if (acc && ctl.keep) begin
      col_nxt  = wrap ? '0 : col_p1[COL_W-1:0];
      row_nxt  = row_p;
      pend_nxt = pend_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= WID_W'(640);
      h_r    <= HGT_W'(480);
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
    end else begin
      w_r    <= w_nxt;
      h_r    <= h_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

// File: src/edge_nonmax_suppression.sv
`timescale 1ns / 1ps
// Edge non-maximum suppression top level: row-store ram, window cells, compare, output
// Throughput: one transaction per cycle unless a result waits on out_ready; the row-store
// ram reads in the accept cycle and writes back when the result stage fires, with a bypass
// for back-to-back hits on one column. A result passes the result stage, then the output
// register; a pixel's result is caused one row plus one pixel later.
// Reset: synchronous active-low; width 640, height 480, counters and window cleared;
// a fill mark makes unwritten row-store entries read as zero, no clearing pass.
module edge_nonmax_suppression
  import nms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_opcode,
  input  logic [7:0]       in_magnitude,
  input  logic [1:0]       in_direction_code,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_thinned_magnitude,
  output logic             out_frame_end
);

  ctl_t ctl;
  logic acc, a_go, b_fire, rd_ok, fwd_hit;

  logic              b_valid_r, b_valid_nxt;
  logic [COL_W-1:0]  b_col_r;
  mag_t              b_m_r;
  dir_e              b_d_r;
  logic              b_emit_r, b_vl_r, b_vr_r, b_vu_r, b_vd_r, b_fe_r;
  logic              b_rdok_r, b_fwd_r;
  store_word_t       fwd_word_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic              out_valid_r, out_valid_nxt;
  mag_t              out_mag_r;
  logic              out_fe_r;

  dir_e              cur_dir_r, cur_dir_nxt;
  store_word_t       rd_word, word, wr_word;
  logic [$bits(store_word_t)-1:0] ram_rdata;
  column_t           new_col, mid_col, left_col;
  mag_t              a, b, res;

  assign cfg_ready = 1'b1;

  nms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_idx  (cfg_index),
    .cfg_data (cfg_wdata),
    .acc      (acc),
    .opcode   (in_opcode),
    .ctl      (ctl)
  );

  assign b_fire   = b_valid_r && (!b_emit_r || !out_valid_r || out_ready);
  assign in_ready = !b_valid_r || b_fire;
  assign acc      = in_valid && in_ready;
  assign a_go     = acc && ctl.keep;
  assign rd_ok    = {1'b0, ctl.col} < fill_r;
  assign fwd_hit  = b_fire && (b_col_r == ctl.col);

  nms_ram #(
    .WIDTH ($bits(store_word_t)),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (b_fire),
    .waddr (b_col_r),
    .wdata (wr_word),
    .re    (a_go),
    .raddr (ctl.col),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd_word = store_word_t'(ram_rdata);
    if (b_fwd_r) begin
      word = fwd_word_r;
    end else if (b_rdok_r) begin
      word = rd_word;
    end else begin
      word = '0;
    end
    wr_word.upper  = word.center;
    wr_word.center = b_m_r;
    wr_word.dir    = b_d_r;
    new_col.up     = word.upper;
    new_col.mid    = word.center;
    new_col.dn     = b_m_r;
  end

  nms_col_cell u_mid_cell (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (b_fire),
    .col_in  (new_col),
    .col_out (mid_col)
  );

  nms_col_cell u_left_cell (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (b_fire),
    .col_in  (mid_col),
    .col_out (left_col)
  );

  always_comb begin
    case (cur_dir_r)
      DIR_VERT: begin
        a = b_vu_r ? mid_col.up : '0;
        b = b_vd_r ? mid_col.dn : '0;
      end
      DIR_DIAG_UP: begin
        a = (b_vu_r && b_vr_r) ? word.upper : '0;
        b = (b_vd_r && b_vl_r) ? left_col.dn : '0;
      end
      DIR_HORZ: begin
        a = b_vl_r ? left_col.mid : '0;
        b = b_vr_r ? word.center : '0;
      end
      default: begin
        a = (b_vu_r && b_vl_r) ? left_col.up : '0;
        b = (b_vd_r && b_vr_r) ? b_m_r : '0;
      end
    endcase
    res = ((mid_col.mid > a) && (mid_col.mid > b)) ? mid_col.mid : '0;
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (a_go) begin
      b_valid_nxt = 1'b1;
    end else if (b_fire) begin
      b_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (b_fire && b_emit_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    fill_nxt = fill_r;
    if (b_fire && ({1'b0, b_col_r} >= fill_r)) begin
      fill_nxt = {1'b0, b_col_r} + FILL_W'(1);
    end
    cur_dir_nxt = b_fire ? word.dir : cur_dir_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      cur_dir_r   <= DIR_VERT;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      cur_dir_r   <= cur_dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_col_r    <= ctl.col;
      b_m_r      <= (op_e'(in_opcode) == OP_PIXEL) ? in_magnitude : '0;
      b_d_r      <= (op_e'(in_opcode) == OP_PIXEL) ? dir_e'(in_direction_code) : DIR_VERT;
      b_emit_r   <= ctl.emit;
      b_vl_r     <= ctl.vl;
      b_vr_r     <= ctl.vr;
      b_vu_r     <= ctl.vu;
      b_vd_r     <= ctl.vd;
      b_fe_r     <= ctl.fe;
      b_rdok_r   <= rd_ok;
      b_fwd_r    <= fwd_hit;
      fwd_word_r <= wr_word;
    end
    if (b_fire && b_emit_r) begin
      out_mag_r <= res;
      out_fe_r  <= b_fe_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_thinned_magnitude = out_mag_r;
  assign out_frame_end         = out_fe_r;

  // a result only moves into the output register when the slot is free
  assert property (@(posedge clk) disable iff (!rst_n)
    (b_fire && b_emit_r) |-> (!out_valid_r || out_ready))
    else $error("result overwrote a waiting output transaction");

  // a new output transaction always comes from a firing result stage
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(b_fire && b_emit_r))
    else $error("output valid rose without a result");

  // same-column back-to-back transactions take the bypass path
  assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && fwd_hit) |=> (b_valid_r && b_fwd_r))
    else $error("row-store bypass missed");

  // the fill mark never runs past the store depth
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_WIDTH))
    else $error("row-store fill mark out of range");

endmodule
